// File: rtl/sshd_pkg.sv
// Shared types, constants and lookup tables for the seven-segment scanner.
// Used by sshd_front, sshd_back and the top level; depends on nothing else.
package sshd_pkg;

    localparam int VALUE_W        = 16;
    localparam int SEG_W          = 7;
    localparam int INDEX_W        = 2;
    localparam int DEFAULT_DIGITS = 4;

    // Decimal values are at most 9999 when shown, so 14 bits carry them.
    localparam int DEC_W     = 14;
    localparam int RECIP_W   = 25;
    localparam int RECIP_SH  = 24;
    localparam int PROD_W    = DEC_W + RECIP_W;
    localparam int NIBBLE_W  = 4;
    localparam int HEX_PLACES = VALUE_W / NIBBLE_W;

    localparam logic [VALUE_W-1:0] DEC_LIMIT    = 16'd9999;
    localparam logic [SEG_W-1:0]   DASH_PATTERN = 7'h40;

    // Reciprocal of ten for the final remainder step, scaled by 2^16.
    localparam logic [12:0] RECIP_TEN    = 13'd6554;
    localparam int          RECIP_TEN_SH = 16;

    // Per-beat state handed from the quotient stage to the decode stage.
    typedef struct packed {
        logic [DEC_W-1:0]    quotient;
        logic [NIBBLE_W-1:0] nibble;
        logic                decimal;
        logic                overflow;
        logic                beyond;
        logic [INDEX_W-1:0]  index;
    } stage_t;

    // Scaled reciprocal of ten to the power of the digit place.
    function automatic logic [RECIP_W-1:0] recip_for_place(input logic [1:0] place);
        logic [RECIP_W-1:0] r;
        case (place)
            2'd0:    r = 25'd16777216;
            2'd1:    r = 25'd1677722;
            2'd2:    r = 25'd167773;
            default: r = 25'd16778;
        endcase
        return r;
    endfunction

    // Segment pattern for a hexadecimal digit, bit 0 is segment a.
    function automatic logic [SEG_W-1:0] seg_for_digit(input logic [NIBBLE_W-1:0] d);
        logic [SEG_W-1:0] s;
        unique case (d)
            4'h0:    s = 7'h3F;
            4'h1:    s = 7'h06;
            4'h2:    s = 7'h5B;
            4'h3:    s = 7'h4F;
            4'h4:    s = 7'h66;
            4'h5:    s = 7'h6D;
            4'h6:    s = 7'h7D;
            4'h7:    s = 7'h07;
            4'h8:    s = 7'h7F;
            4'h9:    s = 7'h6F;
            4'hA:    s = 7'h77;
            4'hB:    s = 7'h7C;
            4'hC:    s = 7'h39;
            4'hD:    s = 7'h5E;
            4'hE:    s = 7'h79;
            default: s = 7'h71;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/sshd_front.sv
// Front stage: scan position counter, value latch and place quotient.
// Depends on sshd_pkg.
module sshd_front #(
    parameter int NUM_DIGITS = sshd_pkg::DEFAULT_DIGITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          s_valid,
    input  logic [sshd_pkg::VALUE_W-1:0]  s_value_in,
    input  logic                          s_decimal_mode,
    output logic                          stage_valid,
    output sshd_pkg::stage_t              stage_data
);
    import sshd_pkg::*;

    localparam int POS_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_DIGITS - 1);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [VALUE_W-1:0] latched_reg, latched_next;
    logic               valid_reg;
    stage_t             stage_reg, stage_next;

    logic [POS_W-1:0]   place;
    logic [7:0]         place_ext;
    logic [PROD_W-1:0]  product;
    logic               accept;

    assign accept = advance && s_valid;

    always_comb begin
        latched_next = (pos_reg == '0) ? s_value_in : latched_reg;
        pos_next     = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        place        = LAST_POS - pos_reg;
        place_ext    = 8'(place);
        product      = PROD_W'(latched_next[DEC_W-1:0]) *
                       PROD_W'(recip_for_place(place_ext[1:0]));

        stage_next.quotient = product[RECIP_SH +: DEC_W];
        stage_next.nibble   = latched_next[{place_ext[1:0], 2'b00} +: NIBBLE_W];
        stage_next.decimal  = s_decimal_mode;
        stage_next.overflow = s_decimal_mode && (latched_next > DEC_LIMIT);
        stage_next.beyond   = (place_ext >= 8'(HEX_PLACES));
        stage_next.index    = INDEX_W'(pos_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            latched_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            if (advance) begin
                valid_reg <= s_valid;
            end
            if (accept) begin
                pos_reg     <= pos_next;
                latched_reg <= latched_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_data  = stage_reg;

endmodule

// File: rtl/sshd_back.sv
// Back stage: decimal remainder, digit select, segment lookup, result register.
// Depends on sshd_pkg.
module sshd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  logic                          stage_valid,
    input  sshd_pkg::stage_t              stage_data,
    output logic                          m_valid,
    output logic [sshd_pkg::SEG_W-1:0]    m_segments,
    output logic [sshd_pkg::INDEX_W-1:0]  m_digit_index,
    output logic                          m_overflow
);
    import sshd_pkg::*;

    logic                valid_reg;
    logic [SEG_W-1:0]    segments_reg, segments_next;
    logic [INDEX_W-1:0]  index_reg;
    logic                overflow_reg;

    logic [26:0]         tenth_prod;
    logic [DEC_W-1:0]    tenth;
    logic [DEC_W-1:0]    bcd_full;
    logic [NIBBLE_W-1:0] digit;

    always_comb begin
        tenth_prod = 27'(stage_data.quotient) * 27'(RECIP_TEN);
        tenth      = DEC_W'(tenth_prod >> RECIP_TEN_SH);
        bcd_full   = stage_data.quotient - ((tenth << 3) + (tenth << 1));
        if (stage_data.beyond) begin
            digit = '0;
        end else if (stage_data.decimal) begin
            digit = bcd_full[NIBBLE_W-1:0];
        end else begin
            digit = stage_data.nibble;
        end
        segments_next = stage_data.overflow ? DASH_PATTERN : seg_for_digit(digit);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= stage_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && stage_valid) begin
            segments_reg <= segments_next;
            index_reg    <= stage_data.index;
            overflow_reg <= stage_data.overflow;
        end
    end

    assign m_valid       = valid_reg;
    assign m_segments    = segments_reg;
    assign m_digit_index = index_reg;
    assign m_overflow    = overflow_reg;

endmodule

// File: rtl/seven_segment_hex_decimal_scanner_top.sv
// Multiplexed seven-segment scanner, hexadecimal or decimal, one digit per beat.
// An accepted input beat is held in the front stage register, then in the result register.
// Throughput: one beat per cycle unless m_ready stalls; the two pipeline registers advance together.
// Reset (aresetn low, synchronous): scan position and latched value clear to zero,
// both pipeline stages empty. Depends on sshd_pkg, sshd_front and sshd_back.
module seven_segment_hex_decimal_scanner_top #(
    parameter int NUM_DIGITS = sshd_pkg::DEFAULT_DIGITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sshd_pkg::VALUE_W-1:0]  s_value_in,
    input  logic                          s_decimal_mode,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [sshd_pkg::SEG_W-1:0]    m_segments,
    output logic [sshd_pkg::INDEX_W-1:0]  m_digit_index,
    output logic                          m_overflow
);
    import sshd_pkg::*;

    // The whole pipeline moves whenever the result register is empty or its
    // beat is being taken. A new input beat is therefore accepted in the same
    // cycle as a waiting result leaves, so the block runs at full rate.
    logic   advance;
    logic   stage_valid;
    stage_t stage_data;

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;

    // The front stage owns the scan position and the latched value. It works
    // out the quotient of the value by the power of ten for the digit place
    // with a reciprocal multiply, and picks the hexadecimal nibble.
    sshd_front #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .advance        (advance),
        .s_valid        (s_valid),
        .s_value_in     (s_value_in),
        .s_decimal_mode (s_decimal_mode),
        .stage_valid    (stage_valid),
        .stage_data     (stage_data)
    );

    // The back stage reduces the quotient modulo ten, selects the digit,
    // substitutes the dash on decimal overflow and holds the result beat.
    sshd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .stage_valid   (stage_valid),
        .stage_data    (stage_data),
        .m_valid       (m_valid),
        .m_segments    (m_segments),
        .m_digit_index (m_digit_index),
        .m_overflow    (m_overflow)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the seven-segment hex/decimal scanner.
// Needs sshd_pkg and seven_segment_hex_decimal_scanner_top; reads no files.
// A scoreboard class predicts every digit beat and checks the results in order.
`timescale 1ns / 1ps

module tb;
    import sshd_pkg::*;

    // The block is built with its default digit count, and the prediction
    // below assumes the same number of scan positions.
    localparam int DIGITS = DEFAULT_DIGITS;

    // Display base as carried by the decimal_mode field.
    localparam logic MODE_HEX = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    localparam int  RANDOM_ITEMS = 1900;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  MAX_REPORTS  = 10;

    // Families of values that are shown during a well-formed random frame.
    typedef enum int {
        VAL_ANY,
        VAL_DECIMAL,
        VAL_BOUNDARY,
        VAL_REPEAT
    } value_kind_e;

    // One expected digit beat on the result channel.
    typedef struct packed {
        logic [SEG_W-1:0]   segments;
        logic [INDEX_W-1:0] digit_index;
        logic               overflow;
    } digit_beat_t;

    // Scoreboard: holds its own scan position and latched value, works out
    // the digit beat for every accepted input beat and checks the results
    // against those expectations in arrival order.
    class scan_scoreboard;
        digit_beat_t  expected_q[$];
        int unsigned  scan_pos;
        logic [15:0]  shown_value;
        int           mismatches;
        int           results_seen;
        int           dash_beats;
        int           dec_beats;

        // Segment patterns for the sixteen hexadecimal digits, bit 0 is a.
        function logic [SEG_W-1:0] glyph(input logic [3:0] d);
            logic [SEG_W-1:0] lut [16];
            lut = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07,
                    7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h39, 7'h5E, 7'h79, 7'h71};
            return lut[d];
        endfunction

        function void note_input(input logic [15:0] value, input logic dec);
            digit_beat_t beat;
            int unsigned place;
            int unsigned v;
            int unsigned d;
            if (scan_pos == 0)
                shown_value = value;
            place = DIGITS - 1 - scan_pos;
            beat.digit_index = scan_pos[INDEX_W-1:0];
            beat.overflow = 1'b0;
            if (dec == MODE_DEC && shown_value > DEC_LIMIT) begin
                beat.segments = DASH_PATTERN;
                beat.overflow = 1'b1;
            end else if (dec == MODE_DEC) begin
                v = shown_value;
                for (int i = 0; i < place; i++)
                    v = v / 10;
                d = v % 10;
                beat.segments = glyph(d[3:0]);
            end else begin
                d = (place >= 8) ? 0 : (shown_value >> (4 * place)) & 4'hF;
                beat.segments = glyph(d[3:0]);
            end
            if (dec == MODE_DEC)
                dec_beats++;
            expected_q.push_back(beat);
            scan_pos = (scan_pos + 1 >= DIGITS) ? 0 : scan_pos + 1;
        endfunction

        function void check_result(input logic [SEG_W-1:0] seg,
                                   input logic [INDEX_W-1:0] idx,
                                   input logic ovf);
            digit_beat_t want;
            results_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: result beat with nothing expected: seg=%h idx=%0d ovf=%b",
                             seg, idx, ovf);
                return;
            end
            want = expected_q.pop_front();
            if (want.overflow)
                dash_beats++;
            if (seg !== want.segments || idx !== want.digit_index
                    || ovf !== want.overflow) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: beat %0d: expected seg=%h idx=%0d ovf=%b, ",
                             results_seen, want.segments, want.digit_index, want.overflow,
                             "got seg=%h idx=%0d ovf=%b", seg, idx, ovf);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [VALUE_W-1:0]   s_value_in;
    logic                 s_decimal_mode;
    logic                 m_valid;
    logic                 m_ready;
    logic [SEG_W-1:0]     m_segments;
    logic [INDEX_W-1:0]   m_digit_index;
    logic                 m_overflow;

    scan_scoreboard sb;
    int             beats_sent;
    int             burst_left;
    int             cycle_count;

    // Values for the directed hexadecimal frames.
    logic [VALUE_W-1:0] frame_value_list [4] = '{16'h0123, 16'h4567, 16'h89AB, 16'hCDEF};

    seven_segment_hex_decimal_scanner_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value_in     (s_value_in),
        .s_decimal_mode (s_decimal_mode),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_segments     (m_segments),
        .m_digit_index  (m_digit_index),
        .m_overflow     (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Every input starts from a known value; the scoreboard exists before
    // the first clock edge so that the monitor below can always use it.
    initial begin
        sb = new();
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_value_in     <= '0;
        s_decimal_mode <= MODE_HEX;
        m_ready        <= 1'b0;
    end

    // Monitor. Both channels are sampled at the rising edge, so the values
    // seen are those from before the edge. The input beat is noted first in
    // case a result ever follows its input within the same cycle.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_input(s_value_in, s_decimal_mode);
            if (m_valid && m_ready)
                sb.check_result(m_segments, m_digit_index, m_overflow);
        end
    end

    // Receiver back-pressure. A sixteen-bit ready mask is replayed for a
    // random stretch, then a new one is drawn: sometimes fully ready, sometimes
    // light or heavy stalling, so stalls land on every scan position.
    logic [15:0] ready_mask;
    int          mask_left = 0;
    int          mask_bit  = 0;

    always @(posedge aclk) begin
        if (mask_left == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_mask = 16'hFFFF;
                1:       ready_mask = 16'($urandom);
                2:       ready_mask = 16'($urandom) & 16'($urandom);
                default: ready_mask = 16'($urandom) | 16'($urandom);
            endcase
            if (ready_mask == '0)
                ready_mask = 16'h0001;
            mask_left = $urandom_range(16, 200);
        end
        mask_left--;
        m_ready <= ready_mask[mask_bit];
        mask_bit = (mask_bit + 1) % 16;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ERROR: run stopped after %0d cycles without finishing", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one input beat and hold it until the block takes it. The task
    // returns at the edge of acceptance, so the next call keeps valid high
    // without a gap.
    task automatic send_beat(input logic [VALUE_W-1:0] value, input logic dec);
        s_valid        <= 1'b1;
        s_value_in     <= value;
        s_decimal_mode <= dec;
        do
            @(posedge aclk);
        while (!(s_valid && s_ready));
        beats_sent++;
    endtask

    // Sender pacing: beats go out in bursts of random length, with random
    // gaps between bursts. While idle the payload carries junk that the block
    // must ignore. Some bursts are long enough to run at full rate for a while.
    task automatic paced_beat(input logic [VALUE_W-1:0] value, input logic dec);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if ($urandom_range(0, 15) == 0)
                gap = $urandom_range(20, 40);
            if (gap > 0) begin
                s_valid        <= 1'b0;
                s_value_in     <= 16'($urandom);
                s_decimal_mode <= 1'($urandom);
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        send_beat(value, dec);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value(input value_kind_e kind);
        logic [3:0] nib;
        case (kind)
            VAL_DECIMAL:  return 16'($urandom_range(0, 9999));
            VAL_BOUNDARY: return 16'($urandom_range(9990, 10010));
            VAL_REPEAT: begin
                nib = 4'($urandom);
                return {4{nib}};
            end
            default:      return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [VALUE_W-1:0] frame_value;
        logic               frame_mode;
        logic               mixed_modes;
        logic               drift_values;
        value_kind_e        kind;
        int                 pos;

        beats_sent  = 0;
        burst_left  = 0;
        cycle_count = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames, starting at scan position zero after reset.
        // Hexadecimal frames show every nibble value once across the four frames.
        foreach (frame_value_list[i])
            for (int k = 0; k < DIGITS; k++)
                paced_beat(frame_value_list[i], MODE_HEX);
        // Largest value still shown in decimal.
        for (int k = 0; k < DIGITS; k++)
            paced_beat(16'd9999, MODE_DEC);
        // Full-scale value with the base flipping every beat: the dash and
        // the overflow flag must follow the mode of each beat, not the frame.
        for (int k = 0; k < DIGITS; k++)
            paced_beat(16'hFFFF, (k % 2 == 0) ? MODE_DEC : MODE_HEX);

        // Random part. Most of it is aligned frames holding one value, with
        // the base mostly fixed per frame; the rest is noise that changes the
        // value and the base on every beat and leaves the scan position
        // anywhere, after which the next frame first pads up to position zero.
        while (beats_sent < RANDOM_ITEMS + 24) begin
            if ($urandom_range(0, 3) != 0) begin
                pos = beats_sent % DIGITS;
                while (pos != 0) begin
                    paced_beat(16'($urandom), 1'($urandom));
                    pos = beats_sent % DIGITS;
                end
                kind         = value_kind_e'($urandom_range(0, 3));
                frame_value  = pick_value(kind);
                frame_mode   = ($urandom_range(0, 1) == 0) ? MODE_DEC : MODE_HEX;
                mixed_modes  = ($urandom_range(0, 4) == 0);
                drift_values = ($urandom_range(0, 5) == 0);
                for (int k = 0; k < DIGITS; k++) begin
                    // Later beats of a frame may carry other values, which
                    // the block must not pick up before the next frame.
                    paced_beat((drift_values && k != 0) ? 16'($urandom) : frame_value,
                               mixed_modes ? 1'($urandom) : frame_mode);
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    paced_beat(16'($urandom), 1'($urandom));
            end
        end
        s_valid <= 1'b0;

        // Drain: wait for every outstanding digit beat, then wait on with margin
        // so that a stray extra beat from the pipeline is caught.
        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Covered %0d input beats (%0d in decimal mode), %0d result beats checked,",
                 beats_sent, sb.dec_beats, sb.results_seen);
        $display("  %0d of them decimal overflow dashes, %0d mismatches, %0d beats missing.",
                 sb.dash_beats, sb.mismatches, sb.expected_q.size());
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
